/* rtl/psd_pkg.sv */
`default_nettype none
package psd_pkg;
	localparam int COORD_WIDTH = 16;
	localparam int FRAC_BITS = 8;
	localparam int DIST_W = 25;
	localparam int DW = COORD_WIDTH + 1;
	localparam int PW = 2 * DW;
	localparam int CM_W = PW + 1;
	localparam int H_W = (CM_W + 1) / 2;
	localparam int HH_W = CM_W - H_W;
	localparam int SQ_W = 2 * CM_W;
	localparam int NUM_W = SQ_W + 2 * FRAC_BITS;
	localparam int ROOT_BITS = COORD_WIDTH + 2 + FRAC_BITS;
	localparam int DEN_W = CM_W;
	localparam int D_W = ROOT_BITS + DEN_W;
	localparam int REM_W = 2 * ROOT_BITS + DEN_W + 1;
	localparam int OW = (ROOT_BITS > DIST_W) ? ROOT_BITS : DIST_W;

	typedef enum logic [1:0] {
		PART_FOOT  = 2'd0,
		PART_START = 2'd1,
		PART_END   = 2'd2
	} part_t;

	typedef struct packed {
		part_t part;
		logic  degen;
	} psd_side_t;
endpackage
`default_nettype wire

/* rtl/psd_root.sv */
`default_nettype none
module psd_root
	import psd_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 en,
	input  wire logic                 valid_in,
	input  wire logic [NUM_W-1:0]     num,
	input  wire logic [DEN_W-1:0]     den,
	input  wire psd_side_t            side_in,
	output logic                      valid_out,
	output logic [ROOT_BITS-1:0]      root,
	output psd_side_t                 side_out
);
	// one result bit per stage, msb first; rem = num - r*r*den, dacc = r*den
	logic                 valid_s [ROOT_BITS+1];
	logic [REM_W-1:0]     rem_s   [ROOT_BITS+1];
	logic [D_W-1:0]       dacc_s  [ROOT_BITS+1];
	logic [DEN_W-1:0]     den_s   [ROOT_BITS+1];
	logic [ROOT_BITS-1:0] r_s     [ROOT_BITS+1];
	psd_side_t            side_s  [ROOT_BITS+1];

	assign valid_s[0] = valid_in;
	assign rem_s[0]   = REM_W'(num);
	assign dacc_s[0]  = '0;
	assign den_s[0]   = den;
	assign r_s[0]     = '0;
	assign side_s[0]  = side_in;

	for (genvar k = 0; k < ROOT_BITS; k++) begin : g_stage
		localparam int B = ROOT_BITS - 1 - k;
		logic [REM_W-1:0] den_sh;
		logic [REM_W-1:0] trial;
		logic             take;

		always_comb begin
			den_sh = REM_W'(den_s[k]) << B;
			trial  = ((REM_W'(dacc_s[k]) << 1) + den_sh) << B;
			take   = trial <= rem_s[k];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k+1] <= 1'b0;
			end else if (en) begin
				valid_s[k+1] <= valid_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				den_s[k+1]  <= den_s[k];
				side_s[k+1] <= side_s[k];
				if (take) begin
					rem_s[k+1]  <= rem_s[k] - trial;
					dacc_s[k+1] <= dacc_s[k] + D_W'(den_sh);
					r_s[k+1]    <= r_s[k] | (ROOT_BITS'(1) << B);
				end else begin
					rem_s[k+1]  <= rem_s[k];
					dacc_s[k+1] <= dacc_s[k];
					r_s[k+1]    <= r_s[k];
				end
			end
		end
	end

	assign valid_out = valid_s[ROOT_BITS];
	assign root      = r_s[ROOT_BITS];
	assign side_out  = side_s[ROOT_BITS];
endmodule
`default_nettype wire

/* rtl/point_segment_distance.sv */
`default_nettype none
// pipeline: 6 front stages plus one square-root stage per result bit (26 bits)
// throughput: one item per cycle; a stalled output holds the whole pipeline
// reset: arst_n clears all stage valid bits, payload registers are not reset
module point_segment_distance
	import psd_pkg::*;
(
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic                          opcode,
	input  wire logic signed [COORD_WIDTH-1:0] point_x,
	input  wire logic signed [COORD_WIDTH-1:0] point_y,
	input  wire logic signed [COORD_WIDTH-1:0] start_x,
	input  wire logic signed [COORD_WIDTH-1:0] start_y,
	input  wire logic signed [COORD_WIDTH-1:0] end_x,
	input  wire logic signed [COORD_WIDTH-1:0] end_y,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [DIST_W-1:0]                  dist_q8,
	output logic [1:0]                         nearest_part,
	output logic                               degenerate
);
	logic en;
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic seg_s1, seg_s2, seg_s3;
	logic signed [DW-1:0] v1x_s1, v1y_s1, v2x_s1, v2y_s1, wx_s1, wy_s1;
	logic signed [PW-1:0] xx_s2, yy_s2, l1_s2, l2_s2, c1_s2, c2_s2;
	logic signed [PW-1:0] ax_s2, ay_s2, bx_s2, by_s2;
	logic signed [CM_W-1:0] dot_s3, len2_s3, cross_s3, da_s3, db_s3;
	logic [HH_W-1:0] ch_s4;
	logic [H_W-1:0]  cl_s4;
	logic [CM_W-1:0] d2_s4, len2_s4, d2_s5, len2_s5;
	logic            perp_s4, perp_s5;
	psd_side_t       side_s4, side_s5, side_s6;
	logic [2*HH_W-1:0]   hh_s5;
	logic [HH_W+H_W-1:0] hl_s5;
	logic [2*H_W-1:0]    ll_s5;
	logic [NUM_W-1:0] num_s6;
	logic [DEN_W-1:0] den_s6;

	// stage 4 decision and stage 6 cross-square sum
	logic            degen_c, before_c, after_c, perp_c;
	logic [CM_W-1:0] cmag_c;
	psd_side_t       side_c;
	logic [SQ_W-1:0] sq_c;

	always_comb begin
		degen_c  = len2_s3 == '0;
		before_c = seg_s3 && (dot_s3 < 0);
		after_c  = seg_s3 && (dot_s3 > len2_s3);
		perp_c   = !degen_c && !before_c && !after_c;
		cmag_c   = cross_s3[CM_W-1] ? CM_W'(-cross_s3) : CM_W'(cross_s3);
		side_c.degen = degen_c;
		if (degen_c || before_c) begin
			side_c.part = PART_START;
		end else if (after_c) begin
			side_c.part = PART_END;
		end else begin
			side_c.part = PART_FOOT;
		end
		sq_c = (SQ_W'(hh_s5) << (2 * H_W)) + (SQ_W'(hl_s5) << (H_W + 1)) + SQ_W'(ll_s5);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			seg_s1 <= opcode;
			v1x_s1 <= DW'(end_x) - DW'(start_x);
			v1y_s1 <= DW'(end_y) - DW'(start_y);
			v2x_s1 <= DW'(point_x) - DW'(start_x);
			v2y_s1 <= DW'(point_y) - DW'(start_y);
			wx_s1  <= DW'(point_x) - DW'(end_x);
			wy_s1  <= DW'(point_y) - DW'(end_y);

			seg_s2 <= seg_s1;
			xx_s2  <= v1x_s1 * v2x_s1;
			yy_s2  <= v1y_s1 * v2y_s1;
			l1_s2  <= v1x_s1 * v1x_s1;
			l2_s2  <= v1y_s1 * v1y_s1;
			c1_s2  <= v1x_s1 * v2y_s1;
			c2_s2  <= v1y_s1 * v2x_s1;
			ax_s2  <= v2x_s1 * v2x_s1;
			ay_s2  <= v2y_s1 * v2y_s1;
			bx_s2  <= wx_s1 * wx_s1;
			by_s2  <= wy_s1 * wy_s1;

			seg_s3   <= seg_s2;
			dot_s3   <= CM_W'(xx_s2) + CM_W'(yy_s2);
			len2_s3  <= CM_W'(l1_s2) + CM_W'(l2_s2);
			cross_s3 <= CM_W'(c1_s2) - CM_W'(c2_s2);
			da_s3    <= CM_W'(ax_s2) + CM_W'(ay_s2);
			db_s3    <= CM_W'(bx_s2) + CM_W'(by_s2);

			perp_s4 <= perp_c;
			side_s4 <= side_c;
			ch_s4   <= cmag_c[CM_W-1:H_W];
			cl_s4   <= cmag_c[H_W-1:0];
			d2_s4   <= after_c ? CM_W'(db_s3) : CM_W'(da_s3);
			len2_s4 <= CM_W'(len2_s3);

			// cross squared split into partial products
			perp_s5 <= perp_s4;
			side_s5 <= side_s4;
			d2_s5   <= d2_s4;
			len2_s5 <= len2_s4;
			hh_s5   <= ch_s4 * ch_s4;
			hl_s5   <= ch_s4 * cl_s4;
			ll_s5   <= cl_s4 * cl_s4;

			side_s6 <= side_s5;
			num_s6  <= (perp_s5 ? NUM_W'(sq_c) : NUM_W'(d2_s5)) << (2 * FRAC_BITS);
			den_s6  <= perp_s5 ? DEN_W'(len2_s5) : DEN_W'(1);
		end
	end

	logic [ROOT_BITS-1:0] root;
	psd_side_t            side_out;
	logic [OW-1:0]        root_ext;

	psd_root u_root (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.valid_in  (v_s6),
		.num       (num_s6),
		.den       (den_s6),
		.side_in   (side_s6),
		.valid_out (out_valid),
		.root      (root),
		.side_out  (side_out)
	);

	always_comb begin
		root_ext = OW'(root);
		if (root_ext > OW'({DIST_W{1'b1}})) begin
			dist_q8 = {DIST_W{1'b1}};
		end else begin
			dist_q8 = DIST_W'(root_ext);
		end
		nearest_part = side_out.part;
		degenerate   = side_out.degen;
	end

	a_part_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (nearest_part != 2'd3))
		else $error("nearest_part out of range");
	a_degen_start: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> (nearest_part == PART_START))
		else $error("degenerate result not at start point");
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(dist_q8))
		else $error("stalled result lost");
	a_perp_sideband: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 && en |=> (perp_s5 == 1'b0) || (den_s6 != '0))
		else $error("zero divisor on perpendicular path");
endmodule
`default_nettype wire
